// File: rtl/core/ctuc_pkg.sv
// Shared constants and types for the counter tick / microsecond converter.
`timescale 1ns / 1ps
`default_nettype none
package ctuc_pkg;
   localparam int AMOUNT_W   = 64;
   localparam int FREQ_W     = 34;
   localparam int HALF_W     = AMOUNT_W / 2;
   localparam int PART_W     = HALF_W + FREQ_W;
   localparam int PROD_W     = AMOUNT_W + FREQ_W;
   localparam int CELL_COUNT = AMOUNT_W;

   localparam logic [FREQ_W-1:0] US_PER_SECOND = FREQ_W'(64'd1000000);
   localparam logic [FREQ_W-1:0] FREQ_MIN_HZ   = FREQ_W'(64'd1000000);
   localparam logic [FREQ_W-1:0] FREQ_MAX_HZ   = FREQ_W'(64'd10000000000);

   localparam logic KIND_US_TO_TICKS = 1'b0;
   localparam logic KIND_TICKS_TO_US = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   // One item on its way through the divider row. w holds the remaining low
   // dividend bits at the top and the quotient bits collected at the bottom.
   typedef struct packed {
      logic                valid;
      logic                kind;
      logic                ovf;
      logic [FREQ_W-1:0]   d;
      logic [FREQ_W-1:0]   r;
      logic [AMOUNT_W-1:0] w;
   } ctuc_cell_type;
endpackage
`default_nettype wire

// File: rtl/core/ctuc_if.sv
// Request and response channel interfaces of the converter.
`timescale 1ns / 1ps
`default_nettype none
interface ctuc_req_if;
   import ctuc_pkg::*;
   logic                valid;
   logic                ready;
   logic                kind;
   logic [AMOUNT_W-1:0] amount;
   modport source (output valid, output kind, output amount, input ready);
   modport sink (input valid, input kind, input amount, output ready);
endinterface

interface ctuc_rsp_if;
   import ctuc_pkg::*;
   logic                valid;
   logic                ready;
   logic [AMOUNT_W-1:0] converted;
   logic                status;
   modport source (output valid, output converted, output status, input ready);
   modport sink (input valid, input converted, input status, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ctuc_mul.sv
// Input register, split 64x34 product and overflow precheck ahead of the divider row.
`timescale 1ns / 1ps
`default_nettype none
module ctuc_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic                          in_kind,
   input  wire logic [ctuc_pkg::AMOUNT_W-1:0] in_amount,
   input  wire logic [ctuc_pkg::FREQ_W-1:0]   freq,
   output ctuc_pkg::ctuc_cell_type            cell_out
);
   import ctuc_pkg::*;

   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                s1_kind_ff, s2_kind_ff, s3_kind_ff;
   logic [AMOUNT_W-1:0] s1_a_ff;
   logic [FREQ_W-1:0]   s1_b_ff, s1_d_ff, s2_d_ff, s3_d_ff;
   logic [PART_W-1:0]   pl_ff, ph_ff, pl_in, ph_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   ctuc_cell_type       cell_ff, cell_in;

   // kind 0: freq * us / 1e6, kind 1: ticks * 1e6 / freq
   assign pl_in   = PART_W'(s1_a_ff[HALF_W-1:0]) * PART_W'(s1_b_ff);
   assign ph_in   = PART_W'(s1_a_ff[AMOUNT_W-1:HALF_W]) * PART_W'(s1_b_ff);
   assign prod_in = {ph_ff, HALF_W'(0)} + PROD_W'(pl_ff);

   always_comb begin
      cell_in.valid = s3_valid_ff;
      cell_in.kind  = s3_kind_ff;
      cell_in.d     = s3_d_ff;
      cell_in.r     = prod_ff[PROD_W-1:AMOUNT_W];
      cell_in.w     = prod_ff[AMOUNT_W-1:0];
      // quotient fits in 64 bits only if the high part is below the divisor
      cell_in.ovf   = prod_ff[PROD_W-1:AMOUNT_W] >= s3_d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s1_kind_ff  <= in_kind;
         s1_a_ff     <= in_amount;
         s1_b_ff     <= (in_kind == KIND_US_TO_TICKS) ? freq : US_PER_SECOND;
         s1_d_ff     <= (in_kind == KIND_US_TO_TICKS) ? US_PER_SECOND : freq;
         s2_valid_ff <= s1_valid_ff;
         s2_kind_ff  <= s1_kind_ff;
         s2_d_ff     <= s1_d_ff;
         pl_ff       <= pl_in;
         ph_ff       <= ph_in;
         s3_valid_ff <= s2_valid_ff;
         s3_kind_ff  <= s2_kind_ff;
         s3_d_ff     <= s2_d_ff;
         prod_ff     <= prod_in;
         cell_ff     <= cell_in;
      end
   end

   assign cell_out = cell_ff;
endmodule
`default_nettype wire

// File: rtl/core/ctuc_cell.sv
// One restoring-division step: shift in a dividend bit, subtract if it fits.
`timescale 1ns / 1ps
`default_nettype none
module ctuc_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  ctuc_pkg::ctuc_cell_type cell_in,
   output ctuc_pkg::ctuc_cell_type cell_out
);
   import ctuc_pkg::*;

   logic [FREQ_W:0] trial, diff;
   logic            ge;
   ctuc_cell_type   cell_ff, cell_nx;

   assign trial = {cell_in.r, cell_in.w[AMOUNT_W-1]};
   assign diff  = trial - {1'b0, cell_in.d};
   assign ge    = trial >= {1'b0, cell_in.d};

   always_comb begin
      cell_nx   = cell_in;
      cell_nx.r = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
      cell_nx.w = {cell_in.w[AMOUNT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_nx;
      end
   end

   assign cell_out = cell_ff;
endmodule
`default_nettype wire

// File: rtl/core/ctuc_round.sv
// Round-up for microseconds to ticks and final overflow folding.
`timescale 1ns / 1ps
`default_nettype none
module ctuc_round (
   input  ctuc_pkg::ctuc_cell_type            cell_in,
   output logic [ctuc_pkg::AMOUNT_W-1:0]      converted,
   output logic                               status
);
   import ctuc_pkg::*;

   logic round_up;
   logic round_ovf;

   assign round_up  = (cell_in.kind == KIND_US_TO_TICKS) && (cell_in.r != '0);
   // rounding past all-ones is an overflow too
   assign round_ovf = round_up && (&cell_in.w);
   assign status    = (cell_in.ovf || round_ovf) ? STATUS_OVERFLOW : STATUS_OK;
   assign converted = (status == STATUS_OVERFLOW) ? '0 :
                      round_up ? cell_in.w + AMOUNT_W'(1) : cell_in.w;
endmodule
`default_nettype wire

// File: rtl/core/counter_time_unit_converter.sv
// Top level of the counter tick / microsecond converter.
// Converts microseconds to ticks (kind 0, rounded up) or ticks to microseconds
// (kind 1, rounded down) exactly for the counter rate in csr_wdata, clamped to
// 1 MHz..10 GHz when written. Takes one item per clock unless the output stage
// is full. A request passes through the input register, split multiply, product
// sum and overflow precheck registers, a register in each of the 64 division
// cells, then the response register. A two-deep output stage lets the pipeline
// keep advancing after the response side stalls, until a result fills its second
// entry. A result above 2^64-1 returns converted 0 with status 1.
`timescale 1ns / 1ps
`default_nettype none
module counter_time_unit_converter (
   input  wire logic                        clock,
   input  wire logic                        reset,
   ctuc_req_if.sink                         req_chan,
   ctuc_rsp_if.source                       rsp_chan,
   input  wire logic                        csr_we,
   input  wire logic [ctuc_pkg::FREQ_W-1:0] csr_wdata
);
   import ctuc_pkg::*;

   logic [FREQ_W-1:0]   freq_ff;
   logic                en;
   ctuc_cell_type       chain [CELL_COUNT+1];
   logic [AMOUNT_W-1:0] res_conv;
   logic                res_status;
   logic                rsp_valid_ff, skid_valid_ff;
   logic [AMOUNT_W-1:0] rsp_conv_ff, skid_conv_ff;
   logic                rsp_status_ff, skid_status_ff;
   logic                out_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= FREQ_MIN_HZ;
      end else if (csr_we) begin
         if (csr_wdata < FREQ_MIN_HZ) begin
            freq_ff <= FREQ_MIN_HZ;
         end else if (csr_wdata > FREQ_MAX_HZ) begin
            freq_ff <= FREQ_MAX_HZ;
         end else begin
            freq_ff <= csr_wdata;
         end
      end
   end

   assign en             = !skid_valid_ff;
   assign req_chan.ready = en;
   assign out_take       = rsp_valid_ff && rsp_chan.ready;

   ctuc_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .in_kind   (req_chan.kind),
      .in_amount (req_chan.amount),
      .freq      (freq_ff),
      .cell_out  (chain[0])
   );

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      ctuc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   ctuc_round u_round (
      .cell_in   (chain[CELL_COUNT]),
      .converted (res_conv),
      .status    (res_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (en) begin
         if (chain[CELL_COUNT].valid) begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_ff  <= 1'b1;
               rsp_conv_ff   <= res_conv;
               rsp_status_ff <= res_status;
            end else begin
               skid_valid_ff  <= 1'b1;
               skid_conv_ff   <= res_conv;
               skid_status_ff <= res_status;
            end
         end else if (out_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end else if (out_take) begin
         rsp_conv_ff   <= skid_conv_ff;
         rsp_status_ff <= skid_status_ff;
         skid_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.converted = rsp_conv_ff;
   assign rsp_chan.status    = rsp_status_ff;

   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a result while response register is empty");

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_OVERFLOW) |-> (rsp_conv_ff == '0))
      else $error("overflow response carries nonzero value");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_take) |=> (!skid_valid_ff && rsp_valid_ff))
      else $error("skid entry lost on response transfer");
endmodule
`default_nettype wire
